FILE: hdl/are_pkg.sv
package are_pkg;

	localparam int PRECISION_DEF    = 32;
	localparam int SYMBOL_COUNT_DEF = 512;
	localparam int COUNT_BITS_DEF   = 16;

	// cap on decided bits per encode transaction
	localparam int MAX_RESULTS = 32;

	localparam int REQ_W    = 2;
	localparam int SYM_W    = 9;
	localparam int CUM_W    = 16;
	localparam int TOTAL_W  = 16;
	localparam int FOLLOW_W = 32;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;

	localparam logic [FOLLOW_W-1:0] PEND_MAX = '1;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD   = 2'd0,
		REQ_ENCODE = 2'd1,
		REQ_FINISH = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_HI,
		ST_DIV_HI,
		ST_MUL_LO,
		ST_DIV_LO,
		ST_E12,
		ST_E3,
		ST_FIN
	} state_t;

endpackage

FILE: hdl/are_div.sv
// Restoring divider, one quotient bit per cycle. Keeps the low QW quotient bits.
module are_div #(
	parameter int DW = 49,
	parameter int VW = 16,
	parameter int QW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quotient
);

	localparam int CNW = $clog2(DW + 1);

	logic [DW-1:0]  dvd_q;
	logic [VW-1:0]  rem_q;
	logic [VW-1:0]  dsr_q;
	logic [QW-1:0]  quo_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [VW:0] trial;
	logic        qbit;
	logic [VW:0] diff;

	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
		diff  = trial - {1'b0, dsr_q};
		qbit  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNW'(1);
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= qbit ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hdl/arithmetic_range_encoder_top.sv
// Static-model binary arithmetic encoder.
// Input stream (s_*): one transaction per request. s_tuser carries the request
// kind: load a table entry, encode a symbol, or finish the stream. A load writes
// the table entry when it is accepted. An encode reads the count table, then scales
// the interval with one shared multiplier and one shared bit-serial divider, used
// first for the high count and then for the low count; the divider gives one
// quotient bit per cycle. Then it emits one decided bit (E1/E2 shift) per cycle
// while the receiver takes them, does one E3 shift per cycle, and leaves each
// of those two phases when no further shift applies.
// A finish emits its closing bit once the output register is free.
// s_tready is high only while the sequencer is idle.
// Output stream (m_*): each decided bit with its count of opposite follow bits;
// m_tlast marks the last transaction caused by one input. A stalled receiver
// holds the sequencer at its next output; nothing is dropped.
// cfg_we/cfg_wdata write the total count; zero acts as one. Write only while idle.
// Reset clears the interval to [0, 2^PRECISION], the pending count and the
// total (to 1). The count tables are not cleared: encode only loaded symbols.
module arithmetic_range_encoder_top
	import are_pkg::*;
#(
	parameter int PRECISION    = PRECISION_DEF,
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // symbol[8:0], cum_low[24:9], cum_high[40:25]
	input  logic [REQ_W-1:0]     s_tuser,   // req_type[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // out_bit[0], follow_count[32:1]
	output logic                 m_tlast,   // last_of_run
	input  logic                 cfg_we,
	input  logic [TOTAL_W-1:0]   cfg_wdata
);

	localparam int IW  = PRECISION + 1;
	localparam int CW  = COUNT_BITS;
	localparam int AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int PW  = IW + CW;
	localparam int NCW = $clog2(MAX_RESULTS + 1);
	localparam int ECW = $clog2(PRECISION + 1);

	localparam logic [IW-1:0] WHOLE_V   = IW'(1) << PRECISION;
	localparam logic [IW-1:0] HALF_V    = IW'(1) << (PRECISION - 1);
	localparam logic [IW-1:0] QUARTER_V = IW'(1) << (PRECISION - 2);
	localparam logic [IW-1:0] THREE_Q_V = QUARTER_V + (QUARTER_V << 1);

	state_t state_q, state_d;

	// input field split
	req_t           req;
	logic [SYM_W-1:0] sym;
	logic [CW-1:0]  in_lo_cnt;
	logic [CW-1:0]  in_hi_cnt;
	logic           sym_ok;
	logic           in_acc;

	assign req       = req_t'(s_tuser);
	assign sym       = s_tdata[8:0];
	assign in_lo_cnt = CW'(s_tdata[24:9]);
	assign in_hi_cnt = CW'(s_tdata[40:25]);
	assign sym_ok    = (32'(sym) < 32'(SYMBOL_COUNT));
	assign in_acc    = s_tvalid && s_tready;

	// count table: {high, low} per symbol
	logic [2*CW-1:0] tbl_mem [SYMBOL_COUNT];
	logic [2*CW-1:0] tbl_rd_q;

	logic [CW-1:0]       total_q;
	logic [IW-1:0]       low_q, high_q, sh_q;
	logic [FOLLOW_W-1:0] pend_q;
	logic [NCW-1:0]      n_q;
	logic [ECW-1:0]      e3_q;

	logic                m_tvalid_q;
	logic                out_bit_q;
	logic [FOLLOW_W-1:0] follow_q;
	logic                last_q;

	// shared scaling unit
	logic [CW-1:0] divisor;
	logic [IW-1:0] range;
	logic [CW-1:0] mul_cnt;
	logic [PW-1:0] product;
	logic          div_start;
	logic          div_done;
	logic [IW-1:0] quotient;

	assign divisor = (total_q == '0) ? CW'(1) : total_q;
	assign range   = high_q - low_q;
	assign mul_cnt = (state_q == ST_MUL_HI) ? tbl_rd_q[2*CW-1:CW] : tbl_rd_q[CW-1:0];
	assign product = PW'(range) * PW'(mul_cnt);

	are_div #(
		.DW(PW),
		.VW(CW),
		.QW(IW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(product),
		.divisor (divisor),
		.done    (div_done),
		.quotient(quotient)
	);

	// renormalization decisions
	logic          out_free;
	logic          e12_go;
	logic          e12_lower;
	logic [IW-1:0] low_sh, high_sh;
	logic          e12_more;
	logic          e3_go;
	logic [FOLLOW_W-1:0] pend_inc;

	assign out_free  = !m_tvalid_q || m_tready;
	assign e12_lower = (high_q < HALF_V);
	assign e12_go    = (e12_lower || (low_q > HALF_V)) && (n_q < NCW'(MAX_RESULTS));
	assign low_sh    = e12_lower ? (low_q << 1) : ((low_q - HALF_V) << 1);
	assign high_sh   = e12_lower ? (high_q << 1) : ((high_q - HALF_V) << 1);
	assign e12_more  = ((high_sh < HALF_V) || (low_sh > HALF_V))
	                   && (n_q < NCW'(MAX_RESULTS - 1));
	assign e3_go     = (low_q > QUARTER_V) && (high_q < THREE_Q_V)
	                   && (e3_q < ECW'(PRECISION));
	assign pend_inc  = (pend_q == PEND_MAX) ? pend_q : pend_q + FOLLOW_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (req)
						REQ_ENCODE: if (sym_ok) state_d = ST_MUL_HI;
						REQ_FINISH: state_d = ST_FIN;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL_HI: state_d = ST_DIV_HI;
			ST_DIV_HI: if (div_done) state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_DIV_LO;
			ST_DIV_LO: if (div_done) state_d = ST_E12;
			ST_E12:    if (!e12_go) state_d = ST_E3;
			ST_E3:     if (!e3_go) state_d = ST_IDLE;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	logic tbl_we, tbl_re, e12_emit, fin_emit;

	always_comb begin
		tbl_we    = 1'b0;
		tbl_re    = 1'b0;
		div_start = 1'b0;
		e12_emit  = 1'b0;
		fin_emit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				tbl_we = in_acc && (req == REQ_LOAD) && sym_ok;
				tbl_re = in_acc && (req == REQ_ENCODE) && sym_ok;
			end
			ST_MUL_HI, ST_MUL_LO: div_start = 1'b1;
			ST_E12:  e12_emit = e12_go && out_free;
			ST_FIN:  fin_emit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[AW'(sym)] <= {in_hi_cnt, in_lo_cnt};
		if (tbl_re) tbl_rd_q <= tbl_mem[AW'(sym)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= CW'(1);
			low_q      <= '0;
			high_q     <= WHOLE_V;
			sh_q       <= '0;
			pend_q     <= '0;
			n_q        <= '0;
			e3_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) total_q <= CW'(cfg_wdata);

			if (state_q == ST_DIV_HI && div_done) sh_q <= quotient;
			if (state_q == ST_DIV_LO && div_done) begin
				high_q <= low_q + sh_q;
				low_q  <= low_q + quotient;
				n_q    <= '0;
			end

			if (e12_emit) begin
				low_q  <= low_sh;
				high_q <= high_sh;
				pend_q <= '0;
				n_q    <= n_q + NCW'(1);
			end
			if (state_q == ST_E12 && !e12_go) e3_q <= '0;

			if (state_q == ST_E3 && e3_go) begin
				low_q  <= (low_q - QUARTER_V) << 1;
				high_q <= (high_q - QUARTER_V) << 1;
				pend_q <= pend_inc;
				e3_q   <= e3_q + ECW'(1);
			end

			if (fin_emit) begin
				low_q  <= '0;
				high_q <= WHOLE_V;
				pend_q <= '0;
			end

			if (e12_emit || fin_emit) m_tvalid_q <= 1'b1;
			else if (m_tready)        m_tvalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (e12_emit) begin
			out_bit_q <= e12_lower;
			follow_q  <= pend_q;
			last_q    <= !e12_more;
		end else if (fin_emit) begin
			out_bit_q <= (low_q <= QUARTER_V);
			follow_q  <= pend_inc;
			last_q    <= 1'b1;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W - FOLLOW_W - 1)'(0), follow_q, out_bit_q};
	assign m_tlast  = last_q;

endmodule
